/* design/tcds_pkg.sv */
// Package for the tick counter with deadline slots.
// Holds operation codes, window constants and the control structs shared by the modules.
// No dependencies.
package tcds_pkg;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_REGISTER = 2'd1,
        OP_QUERY    = 2'd2
    } op_t;

    localparam logic [7:0] WINDOW_LEN = 8'hff;
    localparam logic       SLEEP_BIT  = 1'b1;

    localparam int FIRED_W = 4;
    localparam int INDEX_W = 2;
    localparam int COUNT_W = 3;

    typedef struct packed {
        logic tick;
        logic add;
    } slot_cmd_t;

    typedef struct packed {
        logic tick;
        logic asleep;
    } tick_cmd_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] ticks;
    } wake_t;

endpackage

/* design/tcds_tick.sv */
// Tick count and 255-tick wake window counters.
// Depends on tcds_pkg.
module tcds_tick
(
    input  logic               clk,
    input  logic               rst_n,
    input  tcds_pkg::tick_cmd_t cmd,
    output logic [31:0]        ticks_next,
    output tcds_pkg::wake_t    wake
);

    logic [31:0] ticks_reg;
    logic [7:0]  window_reg;
    logic [7:0]  window_next;
    logic [7:0]  sleep_reg;
    logic [7:0]  sleep_next;
    logic [7:0]  window_inc;
    logic [7:0]  sleep_inc;

    always_comb
    begin
        window_inc  = window_reg + 8'd1;
        sleep_inc   = sleep_reg + {7'd0, cmd.asleep & tcds_pkg::SLEEP_BIT};
        ticks_next  = ticks_reg;
        window_next = window_reg;
        sleep_next  = sleep_reg;
        wake        = '0;
        if (cmd.tick)
        begin
            ticks_next  = ticks_reg + 32'd1;
            window_next = window_inc;
            sleep_next  = sleep_inc;
            // Close the window: report awake ticks, restart both counters
            if (window_inc == tcds_pkg::WINDOW_LEN)
            begin
                wake.valid  = 1'b1;
                wake.ticks  = tcds_pkg::WINDOW_LEN - sleep_inc;
                window_next = 8'd0;
                sleep_next  = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg  <= '0;
            window_reg <= '0;
            sleep_reg  <= '0;
        end
        else
        begin
            ticks_reg  <= ticks_next;
            window_reg <= window_next;
            sleep_reg  <= sleep_next;
        end
    end

endmodule

/* design/tcds_slots.sv */
// Alarm slot bank: valid bits, deadlines, per-slot compare, allocation and occupancy count.
// Depends on tcds_pkg.
module tcds_slots
#(
    parameter int SLOTS = 4,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    parameter int CNT_W = $clog2(SLOTS + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tcds_pkg::slot_cmd_t cmd,
    input  logic [31:0]         deadline,
    input  logic [31:0]         ticks_next,
    output logic [SLOTS-1:0]    fired,
    output logic                accepted,
    output logic [IDX_W-1:0]    index,
    output logic [CNT_W-1:0]    in_use
);

    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    logic [31:0]      deadline_reg [SLOTS];

    always_comb
    begin
        fired      = '0;
        accepted   = 1'b0;
        index      = '0;
        valid_next = valid_reg;
        // Lowest free slot wins: scan from the top so the lowest is written last
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                accepted = 1'b1;
                index    = IDX_W'(i);
            end
        end
        if (cmd.tick)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (valid_reg[i] && (deadline_reg[i] < ticks_next))
                begin
                    fired[i]      = 1'b1;
                    valid_next[i] = 1'b0;
                end
            end
            accepted = 1'b0;
            index    = '0;
        end
        else if (cmd.add)
        begin
            if (accepted)
            begin
                valid_next[index] = 1'b1;
            end
        end
        else
        begin
            accepted = 1'b0;
            index    = '0;
        end
    end

    always_comb
    begin
        in_use = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            in_use = in_use + CNT_W'(valid_next[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add && accepted)
        begin
            deadline_reg[index] <= deadline;
        end
    end

endmodule

/* design/tick_counter_with_deadline_slots_core.sv */
// Top level of the tick counter with deadline alarm slots.
// Depends on tcds_pkg, tcds_tick and tcds_slots.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------------
//  command  | start high, busy low | operation, asleep, deadline
//  result   | done strobe          | fired_mask, accepted, slot_index, slots_in_use,
//           |                      | wake_valid, wake_ticks, tick_count
//
// One command is taken every cycle; busy stays low. A transfer is captured in the
// input register, processed by the tick counters and the slot bank in the next cycle,
// and its result is captured in the result register that drives the result ports;
// throughput is one item per cycle.
// Reset clears the tick count, window counters, slot valid bits and both strobes.
// The receiver cannot stall; each result is shown for exactly one cycle.
module tick_counter_with_deadline_slots_core
#(
    parameter int SLOTS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic        asleep,
    input  logic [31:0] deadline,
    output logic        done,
    output logic [3:0]  fired_mask,
    output logic        accepted,
    output logic [1:0]  slot_index,
    output logic [2:0]  slots_in_use,
    output logic        wake_valid,
    output logic [7:0]  wake_ticks,
    output logic [31:0] tick_count
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    // Widen before truncating so any slot count maps onto the fixed port widths
    localparam int FIRED_X = (SLOTS > tcds_pkg::FIRED_W) ? SLOTS : tcds_pkg::FIRED_W;
    localparam int INDEX_X = (IDX_W > tcds_pkg::INDEX_W) ? IDX_W : tcds_pkg::INDEX_W;
    localparam int COUNT_X = (CNT_W > tcds_pkg::COUNT_W) ? CNT_W : tcds_pkg::COUNT_W;

    // Input register
    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic        asleep_reg;
    logic [31:0] deadline_reg;

    // Result register
    logic        done_reg;
    logic [3:0]  fired_reg;
    logic        accepted_reg;
    logic [1:0]  index_reg;
    logic [2:0]  in_use_reg;
    logic        wake_valid_reg;
    logic [7:0]  wake_ticks_reg;
    logic [31:0] tick_count_reg;

    tcds_pkg::tick_cmd_t tick_cmd;
    tcds_pkg::slot_cmd_t slot_cmd;
    tcds_pkg::wake_t     wake;
    logic [31:0]         ticks_next;
    logic [SLOTS-1:0]    fired;
    logic                slot_accepted;
    logic [IDX_W-1:0]    slot_idx;
    logic [CNT_W-1:0]    slot_count;
    logic [FIRED_X-1:0]  fired_ext;
    logic [INDEX_X-1:0]  index_ext;
    logic [COUNT_X-1:0]  count_ext;

    // Never hold off a command
    assign busy = 1'b0;

    // Decode the held command; the unused code changes nothing and reports like a query
    always_comb
    begin
        tick_cmd        = '0;
        slot_cmd        = '0;
        tick_cmd.asleep = asleep_reg;
        if (in_valid_reg)
        begin
            unique case (tcds_pkg::op_t'(op_reg))
                tcds_pkg::OP_TICK:
                begin
                    tick_cmd.tick = 1'b1;
                    slot_cmd.tick = 1'b1;
                end
                tcds_pkg::OP_REGISTER:
                begin
                    slot_cmd.add = 1'b1;
                end
                tcds_pkg::OP_QUERY:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    tcds_tick u_tick
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (tick_cmd),
        .ticks_next (ticks_next),
        .wake       (wake)
    );

    tcds_slots
    #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    )
    u_slots
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (slot_cmd),
        .deadline   (deadline_reg),
        .ticks_next (ticks_next),
        .fired      (fired),
        .accepted   (slot_accepted),
        .index      (slot_idx),
        .in_use     (slot_count)
    );

    assign fired_ext = FIRED_X'(fired);
    assign index_ext = INDEX_X'(slot_idx);
    assign count_ext = COUNT_X'(slot_count);

    // Control: transfer strobes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
            done_reg     <= in_valid_reg;
        end
    end

    // Payload: capture the command, then the result of the held command
    always_ff @(posedge clk)
    begin
        op_reg         <= operation;
        asleep_reg     <= asleep;
        deadline_reg   <= deadline;
        fired_reg      <= fired_ext[tcds_pkg::FIRED_W-1:0];
        accepted_reg   <= slot_accepted;
        index_reg      <= index_ext[tcds_pkg::INDEX_W-1:0];
        in_use_reg     <= count_ext[tcds_pkg::COUNT_W-1:0];
        wake_valid_reg <= wake.valid;
        wake_ticks_reg <= wake.ticks;
        tick_count_reg <= ticks_next;
    end

    assign done         = done_reg;
    assign fired_mask   = fired_reg;
    assign accepted     = accepted_reg;
    assign slot_index   = index_reg;
    assign slots_in_use = in_use_reg;
    assign wake_valid   = wake_valid_reg;
    assign wake_ticks   = wake_ticks_reg;
    assign tick_count   = tick_count_reg;

endmodule
